// ----- src/crcab_pkg.sv -----
// crcab_pkg: shared types, register indexes and crc step functions
package crcab_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned RegWidth  = 24;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_POLYNOMIAL     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_INITIAL_VALUE  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_REFLECT_INPUT  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_REFLECT_OUTPUT = 2'd3;

  localparam logic [CrcWidth-1:0] POLY_RESET = 16'h1021;
  localparam logic [CrcWidth-1:0] INIT_RESET = 16'h0000;

  // closed message handed from the byte stage to the tail stages
  typedef struct packed {
    logic                vld;
    logic [RegWidth-1:0] sreg;
  } crcab_item_t;

  // eight shift and conditional xor steps of the augmented register
  function automatic logic [RegWidth-1:0] shift8(input logic [RegWidth-1:0] r,
                                                 input logic [CrcWidth-1:0] poly);
    logic [RegWidth:0] t;
    t = {1'b0, r};
    for (int i = 0; i < ByteWidth; i++) begin
      t = {t[RegWidth-1:0], 1'b0};
      if (t[RegWidth]) begin
        t = t ^ {1'b1, poly, 8'h00};
      end
    end
    return t[RegWidth-1:0];
  endfunction

  function automatic logic [ByteWidth-1:0] flip8(input logic [ByteWidth-1:0] v);
    logic [ByteWidth-1:0] o;
    for (int i = 0; i < ByteWidth; i++) begin
      o[i] = v[ByteWidth-1-i];
    end
    return o;
  endfunction

  function automatic logic [CrcWidth-1:0] flip16(input logic [CrcWidth-1:0] v);
    logic [CrcWidth-1:0] o;
    for (int i = 0; i < CrcWidth; i++) begin
      o[i] = v[CrcWidth-1-i];
    end
    return o;
  endfunction

endpackage

// ----- src/crcab_front.sv -----
// crcab_front: input word register, message state and per-byte crc update
module crcab_front import crcab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ByteWidth-1:0] data_byte,
  input  logic                 byte_valid,
  input  logic                 end_of_message,
  input  logic [CrcWidth-1:0]  polynomial,
  input  logic [CrcWidth-1:0]  initial_value,
  input  logic                 reflect_input,
  input  logic                 tail_ready,
  output crcab_item_t          item
);

  logic                 s0_valid;
  logic                 s0_valid_next;
  logic [ByteWidth-1:0] s0_byte;
  logic                 s0_bv;
  logic                 s0_eom;
  logic [RegWidth-1:0]  sreg;
  logic                 msg_open;

  logic                 accept;
  logic                 consume;
  logic                 active;
  logic [ByteWidth-1:0] byte_in;
  logic [RegWidth-1:0]  base;
  logic [RegWidth-1:0]  after;

  // a word without end of message never waits on the tail
  assign consume  = s0_valid && (!s0_eom || tail_ready);
  assign in_stall = s0_valid && !consume;
  assign accept   = in_valid && !in_stall;
  assign active   = s0_bv || s0_eom;

  assign byte_in = reflect_input ? flip8(s0_byte) : s0_byte;
  assign base    = msg_open ? sreg : {initial_value, 8'h00};
  assign after   = s0_bv ? shift8(base | {16'h0000, byte_in}, polynomial) : base;

  assign item.vld  = consume && s0_eom;
  assign item.sreg = after;

  always_comb begin
    s0_valid_next = s0_valid;
    if (accept) begin
      s0_valid_next = 1'b1;
    end else if (consume) begin
      s0_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      sreg     <= '0;
      msg_open <= 1'b0;
    end else begin
      s0_valid <= s0_valid_next;
      if (consume && active) begin
        sreg     <= after;
        msg_open <= !s0_eom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_byte <= data_byte;
      s0_bv   <= byte_valid;
      s0_eom  <= end_of_message;
    end
  end

endmodule

// ----- src/crcab_tail.sv -----
// crcab_tail: two zero-byte stages and the result register with output reflection
module crcab_tail import crcab_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  crcab_item_t         item,
  output logic                tail_ready,
  input  logic [CrcWidth-1:0] polynomial,
  input  logic                reflect_output,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CrcWidth-1:0] crc_value
);

  logic                s1_valid;
  logic [RegWidth-1:0] s1_reg;
  logic                s2_valid;
  logic [RegWidth-1:0] s2_reg;

  logic                out_ready;
  logic                s2_ready;
  logic                s1_move;
  logic                s2_move;
  logic [RegWidth-1:0] fin;
  logic [CrcWidth-1:0] crc_raw;
  logic [CrcWidth-1:0] crc_next;

  assign out_ready  = !out_valid || !out_stall;
  assign s2_ready   = !s2_valid || out_ready;
  assign tail_ready = !s1_valid || s2_ready;
  assign s1_move    = s1_valid && s2_ready;
  assign s2_move    = s2_valid && out_ready;

  assign fin      = shift8(s2_reg, polynomial);
  assign crc_raw  = fin[RegWidth-1:ByteWidth];
  assign crc_next = reflect_output ? flip16(crc_raw) : crc_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.vld) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (out_ready) begin
        out_valid <= s2_move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.vld) begin
      s1_reg <= item.sreg;
    end
    if (s1_move) begin
      s2_reg <= shift8(s1_reg, polynomial);
    end
    if (s2_move) begin
      crc_value <= crc_next;
    end
  end

endmodule

// ----- src/crc16_augmented_bytewise_top.sv -----
// crc16_augmented_bytewise_top: configurable 16-bit augmented crc, one byte per cycle while in_stall is low
//
//   channel   handshake              payload
//   in        in_valid / in_stall    data_byte, byte_valid, end_of_message
//   out       out_valid / out_stall  crc_value
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one input word per cycle while in_stall is low; the eight-step shift/xor per byte sets the loop
// the crc word of a closed message shows on out once the closing word has passed
// the input register, the two zero-byte stages and the result register
// synchronous reset clears the message state and all stage valids
// a stalled result backs up the tail stages before in_stall rises
module crc16_augmented_bytewise_top import crcab_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ByteWidth-1:0]   data_byte,
  input  logic                   byte_valid,
  input  logic                   end_of_message,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CrcWidth-1:0]    crc_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CrcWidth-1:0]    cfg_data
);

  logic [CrcWidth-1:0] polynomial;
  logic [CrcWidth-1:0] initial_value;
  logic                reflect_input;
  logic                reflect_output;
  logic                tail_ready;
  crcab_item_t         item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial     <= POLY_RESET;
      initial_value  <= INIT_RESET;
      reflect_input  <= 1'b0;
      reflect_output <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLYNOMIAL:     polynomial     <= cfg_data;
        CFG_INITIAL_VALUE:  initial_value  <= cfg_data;
        CFG_REFLECT_INPUT:  reflect_input  <= cfg_data[0];
        CFG_REFLECT_OUTPUT: reflect_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  crcab_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .polynomial     (polynomial),
    .initial_value  (initial_value),
    .reflect_input  (reflect_input),
    .tail_ready     (tail_ready),
    .item           (item)
  );

  crcab_tail u_tail (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .tail_ready     (tail_ready),
    .polynomial     (polynomial),
    .reflect_output (reflect_output),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .crc_value      (crc_value)
  );

  // tail can only be full when a result word is held back
  a_tail_full_needs_stall: assert property (@(posedge clk) disable iff (rst)
    !tail_ready |-> (out_valid && out_stall))
    else $error("tail full without a stalled result");

  // input backs up only behind a full tail
  a_in_stall_needs_tail: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !tail_ready)
    else $error("input stalled while tail has room");

  // a closed message is handed over only when the tail has room
  a_item_has_room: assert property (@(posedge clk) disable iff (rst)
    item.vld |-> tail_ready)
    else $error("closed message dropped at tail");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
